@@ rtl/core/imu_complementary_tilt_filter_assert.svh @@
// assertion macros for the tilt filter, clocked on clk, quiet during reset
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// condition implies consequence in the same cycle
`define CTF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define CTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ctf_pkg.sv @@
`default_nettype none
package ctf_pkg;

    // datapath widths
    localparam int ACC_W    = 22;  // scaled acceleration, 2^-16 m/s^2
    localparam int RATE_W   = 29;  // scaled rate, 2^-24 rad/s
    localparam int ANG_W    = 29;  // cordic angle, 2^-24 rad
    localparam int ST_W     = 28;  // angle state, 2^-24 rad
    localparam int DIFF_W   = 30;
    localparam int MAG_W    = 16;  // magnitude of a raw word
    localparam int PROD_W   = 31;  // magnitude times the fractional gain
    localparam int DSR_W    = 18;
    localparam int QUO_W    = 28;
    localparam int QE_W     = 16;  // quotient of the fractional part
    localparam int RCP_W    = 15;
    localparam int EST_W    = 47;
    localparam int WHOLE_W  = 13;
    localparam int FRAC_W   = 16;
    localparam int ACC_SHIFT  = 31;
    localparam int RATE_SHIFT = 30;
    localparam int ROOT_W   = 22;
    localparam int RAD_W    = 10;
    localparam int CIN_W    = 31;
    localparam int ATAN_LEN = 24;
    localparam int ATAN_W   = 24;

    // scaling constants: gain/divisor split into a whole part and a remainder,
    // the remainder divided through a reciprocal of 2^shift/divisor
    localparam logic [WHOLE_W-1:0] ACCEL_WHOLE = 13'd39;
    localparam logic [FRAC_W-1:0]  ACCEL_FRAC  = 16'd54803;
    localparam logic [RCP_W-1:0]   ACCEL_RECIP = 15'd13152;
    localparam logic [DSR_W-1:0]   ACCEL_DIV   = 18'd163275;
    localparam logic [WHOLE_W-1:0] RATE_WHOLE  = 13'd4483;
    localparam logic [FRAC_W-1:0]  RATE_FRAC   = 16'd29638;
    localparam logic [RCP_W-1:0]   RATE_RECIP  = 15'd18267;
    localparam logic [DSR_W-1:0]   RATE_DIV    = 18'd58779;
    localparam logic signed [ANG_W-1:0] PI_Q   = 29'sd52707179;
    localparam logic signed [ST_W-1:0]  ANGLE_LIMIT = 28'sd67108864;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DWAIT,
        S_SQY,
        S_SQZ,
        S_ROOT,
        S_RWAIT,
        S_CORP,
        S_CWAITP,
        S_CORR,
        S_CWAITR,
        S_DIFF,
        S_BMUL,
        S_BADD,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        CH_AX,
        CH_AY,
        CH_AZ,
        CH_GX,
        CH_GY
    } chan_t;

    // arctangent of 2^-i in units of 2^-24 rad
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 24'd13176795;
                5'd1:    v = 24'd7778716;
                5'd2:    v = 24'd4110060;
                5'd3:    v = 24'd2086331;
                5'd4:    v = 24'd1047214;
                5'd5:    v = 24'd524117;
                5'd6:    v = 24'd262123;
                5'd7:    v = 24'd131069;
                5'd8:    v = 24'd65536;
                5'd9:    v = 24'd32768;
                5'd10:   v = 24'd16384;
                5'd11:   v = 24'd8192;
                5'd12:   v = 24'd4096;
                5'd13:   v = 24'd2048;
                5'd14:   v = 24'd1024;
                5'd15:   v = 24'd512;
                5'd16:   v = 24'd256;
                5'd17:   v = 24'd128;
                5'd18:   v = 24'd64;
                5'd19:   v = 24'd32;
                5'd20:   v = 24'd16;
                5'd21:   v = 24'd8;
                5'd22:   v = 24'd4;
                5'd23:   v = 24'd2;
                default: v = 24'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/ctf_div.sv @@
`default_nettype none
module ctf_div
    import ctf_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire [MAG_W-1:0]   mag,
    input  wire               acc_sel,
    output logic              done,
    output logic [QUO_W-1:0]  quotient
);

    localparam logic [1:0] LAST_PHASE = 2'd2;

    logic [1:0]        phase_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              acc_reg;
    logic [PROD_W-1:0] p_reg;
    logic [QUO_W-1:0]  base_reg;
    logic [QE_W-1:0]   qe_reg;
    logic [PROD_W-1:0] back_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [WHOLE_W-1:0] whole_gain;
    logic [FRAC_W-1:0]  frac_gain;
    logic [31:0]        p_full;
    logic [31:0]        base_full;
    logic [RCP_W-1:0]   recip;
    logic [DSR_W-1:0]   dsr;
    logic [EST_W-1:0]   est_full;
    logic [QE_W-1:0]    qe_next;
    logic [33:0]        back_full;
    logic [PROD_W:0]    rem;
    logic               fix;

    // whole part of the gain and the remainder that still needs dividing
    assign whole_gain = acc_sel ? ACCEL_WHOLE : RATE_WHOLE;
    assign frac_gain  = acc_sel ? ACCEL_FRAC : RATE_FRAC;
    assign p_full     = 32'(mag) * 32'(frac_gain);
    assign base_full  = 32'(mag) * 32'(whole_gain);

    // reciprocal estimate, low by at most one, then one compare and correct
    assign recip     = acc_reg ? ACCEL_RECIP : RATE_RECIP;
    assign dsr       = acc_reg ? ACCEL_DIV : RATE_DIV;
    assign est_full  = EST_W'(p_reg) * EST_W'(recip);
    assign qe_next   = acc_reg ? est_full[ACC_SHIFT +: QE_W] : est_full[RATE_SHIFT +: QE_W];
    assign back_full = 34'(qe_reg) * 34'(dsr);
    assign rem       = {1'b0, p_reg} - {1'b0, back_reg};
    assign fix       = (rem >= (PROD_W+1)'(dsr));

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == LAST_PHASE)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // estimate, back product, corrected sum
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= acc_sel;
            p_reg    <= p_full[PROD_W-1:0];
            base_reg <= base_full[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            if (phase_reg == 2'd0)
                qe_reg <= qe_next;
            else if (phase_reg == 2'd1)
                back_reg <= back_full[PROD_W-1:0];
            else
                quo_reg <= base_reg + QUO_W'(qe_reg) + QUO_W'(fix);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ rtl/core/ctf_isqrt.sv @@
`default_nettype none
module ctf_isqrt
    import ctf_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire [RAD_W-1:0]    radicand,
    output logic               done,
    output logic [ROOT_W-1:0]  root
);

    localparam int SQ_W = 44;
    localparam logic [4:0] SQ_STEPS = 5'd22;

    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] root_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [4:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [SQ_W-1:0] trial;
    logic            ge;

    assign trial = root_reg + bit_reg;
    assign ge    = (v_reg >= trial);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // digit-by-digit root, two radicand bits a step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= {{(SQ_W-RAD_W-32){1'b0}}, radicand, 32'd0};
            root_reg <= '0;
            bit_reg  <= {{(SQ_W-43){1'b0}}, 1'b1, 42'd0};
        end
        else if (busy_reg)
        begin
            v_reg    <= ge ? (v_reg - trial) : v_reg;
            root_reg <= ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
            bit_reg  <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/ctf_cordic.sv @@
`default_nettype none
module ctf_cordic
    import ctf_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire signed [CIN_W-1:0]  y_in,
    input  wire signed [CIN_W-1:0]  x_in,
    output logic                    done,
    output logic signed [ANG_W-1:0] angle
);

    localparam int ITERS = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
    localparam int CW    = CIN_W + 2;
    localparam logic [4:0] LAST = 5'(ITERS - 1);

    logic signed [CW-1:0]    x_reg;
    logic signed [CW-1:0]    y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic [4:0]              i_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic signed [CW-1:0]    x_ext;
    logic signed [CW-1:0]    y_ext;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [ANG_W-1:0] step_ang;

    assign x_ext    = CW'(x_in);
    assign y_ext    = CW'(y_in);
    assign xs       = x_reg >>> i_reg;
    assign ys       = y_reg >>> i_reg;
    assign step_ang = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_lut(i_reg)});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                i_reg <= 5'd0;
                if (y_in == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // vectoring rotations; left half plane is turned by pi first, a zero ordinate gives 0 or pi directly
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (y_in == '0)
            begin
                z_reg <= (x_in < 0) ? PI_Q : '0;
                x_reg <= x_ext;
                y_reg <= y_ext;
            end
            else if (x_in < 0)
            begin
                x_reg <= -x_ext;
                y_reg <= -y_ext;
                z_reg <= (y_in >= 0) ? PI_Q : -PI_Q;
            end
            else
            begin
                x_reg <= x_ext;
                y_reg <= y_ext;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[CW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_ang;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_ang;
            end
        end
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule
`default_nettype wire

@@ rtl/core/imu_complementary_tilt_filter.sv @@
// Complementary tilt filter: each input word carries one six-axis sample set and produces
// exactly one output word with the filtered pitch and roll (2^-13 rad) and a flag that is set
// when either angle hit the +/-4 rad limit. The block takes one set at a time and is not ready
// while it works: a set runs through five scaling passes (a reciprocal multiply with one
// correction), a 22-step square root and two CORDIC passes of CORDIC_STEPS iterations
// (at most 24; a pass with zero ordinate does no iterations). A finished word waits in the
// output register, and the next set is accepted meanwhile. step_time (2^-16 s, also the
// blend weight) must be written through cfg_wr_en/cfg_wr_data only while idle; the block
// itself does not enforce it. Reset clears both angles and step_time.
`default_nettype none
`include "imu_complementary_tilt_filter_assert.svh"
module imu_complementary_tilt_filter
    import ctf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  wire  [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // pitch_out, roll_out, clipped, zero pad
    output logic [39:0] m_axis_tdata
);

    state_t state_reg;
    state_t state_next;
    chan_t  chan_reg;

    logic [15:0] step_time_reg;
    logic signed [ST_W-1:0] pitch_state_reg;
    logic signed [ST_W-1:0] roll_state_reg;
    logic roll_sel_reg;
    logic clip_reg;
    logic m_valid_reg;
    logic [39:0] m_data_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic neg_reg;
    logic signed [ACC_W-1:0] axq_reg, ayq_reg, azq_reg;
    logic signed [RATE_W-1:0] rate_roll_reg, rate_pitch_reg;
    logic [40:0] sq_reg;
    logic [8:0]  y2_reg;
    logic signed [ANG_W-1:0] acc_pitch_reg, acc_roll_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W+16:0] bprod_reg;

    logic accept;
    logic div_start, div_done;
    logic sqrt_start, sqrt_done;
    logic cor_start, cor_done;

    // scaling channel selection
    logic signed [15:0] raw;
    logic is_acc;
    logic [15:0] abs_raw;
    logic [15:0] mag;
    logic neg_sel;
    logic [QUO_W-1:0] quo;
    logic signed [RATE_W-1:0] quo_s;

    logic signed [ACC_W-1:0] sq_in;
    logic signed [2*ACC_W-1:0] sq_full;
    logic [RAD_W-1:0] radicand;
    logic [ROOT_W-1:0] root;

    logic signed [CIN_W-1:0] cor_y, cor_x;
    logic signed [ANG_W-1:0] cor_angle;

    logic signed [ST_W-1:0] s_cur;
    logic signed [RATE_W-1:0] rate_cur;
    logic signed [ANG_W-1:0] acc_cur;
    logic signed [DIFF_W+16:0] rnd;
    logic signed [30:0] upd;
    logic signed [31:0] n_full;
    logic signed [ST_W-1:0] n_clamped;
    logic n_clip;

    function automatic logic [15:0] to_out(input logic signed [ST_W-1:0] s);
        logic signed [16:0] v;
        begin
            v = s[ST_W-1:11];
            if (v > 17'sd32767)
                return 16'h7fff;
            return v[15:0];
        end
    endfunction

    assign accept = s_axis_tvalid && s_axis_tready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        sqrt_start    = 1'b0;
        cor_start     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = S_MUL;
            end
            S_MUL:   state_next = S_DIV;
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                    state_next = (chan_reg == CH_GY) ? S_SQY : S_MUL;
            end
            S_SQY:   state_next = S_SQZ;
            S_SQZ:   state_next = S_ROOT;
            S_ROOT:
            begin
                sqrt_start = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (sqrt_done)
                    state_next = S_CORP;
            end
            S_CORP:
            begin
                cor_start  = 1'b1;
                state_next = S_CWAITP;
            end
            S_CWAITP:
            begin
                if (cor_done)
                    state_next = S_CORR;
            end
            S_CORR:
            begin
                cor_start  = 1'b1;
                state_next = S_CWAITR;
            end
            S_CWAITR:
            begin
                if (cor_done)
                    state_next = S_DIFF;
            end
            S_DIFF:  state_next = S_BMUL;
            S_BMUL:  state_next = S_BADD;
            S_BADD:  state_next = roll_sel_reg ? S_DONE : S_DIFF;
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // channel for the current scaling pass
    always_comb
    begin
        unique case (chan_reg)
            CH_AX:   raw = ax_reg;
            CH_AY:   raw = ay_reg;
            CH_AZ:   raw = az_reg;
            CH_GX:   raw = gx_reg;
            CH_GY:   raw = gy_reg;
            default: raw = ax_reg;
        endcase
    end

    // accel words are negated with saturation, so the most negative word gives 32767
    assign is_acc  = (chan_reg == CH_AX) || (chan_reg == CH_AY) || (chan_reg == CH_AZ);
    assign abs_raw = raw[15] ? 16'(-raw) : 16'(raw);
    assign mag     = (is_acc && raw == 16'sh8000) ? 16'd32767 : abs_raw;
    assign neg_sel = is_acc ? (!raw[15] && raw != 16'sd0) : raw[15];

    // scaled magnitude gets its sign back, truncation is toward zero
    assign quo_s     = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    // squares for the tilt magnitude
    assign sq_in    = (state_reg == S_SQY) ? ayq_reg : azq_reg;
    assign sq_full  = sq_in * sq_in;
    assign radicand = {1'b0, y2_reg} + {1'b0, sq_reg[40:32]};

    // cordic operands, scaled by 256
    assign cor_y = (state_reg == S_CORP) ? {{(CIN_W-ACC_W-8){axq_reg[ACC_W-1]}}, axq_reg, 8'd0}
                                         : {{(CIN_W-ACC_W-8){ayq_reg[ACC_W-1]}}, ayq_reg, 8'd0};
    assign cor_x = (state_reg == S_CORP) ? $signed({1'b0, root, 8'd0})
                                         : {{(CIN_W-ACC_W-8){azq_reg[ACC_W-1]}}, azq_reg, 8'd0};

    // blend of the selected angle
    assign s_cur    = roll_sel_reg ? roll_state_reg : pitch_state_reg;
    assign rate_cur = roll_sel_reg ? rate_roll_reg : rate_pitch_reg;
    assign acc_cur  = roll_sel_reg ? acc_roll_reg : acc_pitch_reg;
    assign rnd      = bprod_reg + (DIFF_W+17)'(32768);
    assign upd      = rnd[DIFF_W+16:16];
    assign n_full   = 32'(s_cur) + 32'(upd);

    always_comb
    begin
        n_clip = 1'b0;
        if (n_full > 32'(ANGLE_LIMIT))
        begin
            n_clamped = ANGLE_LIMIT;
            n_clip    = 1'b1;
        end
        else if (n_full < -32'(ANGLE_LIMIT))
        begin
            n_clamped = -ANGLE_LIMIT;
            n_clip    = 1'b1;
        end
        else
        begin
            n_clamped = n_full[ST_W-1:0];
        end
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg        <= CH_AX;
            step_time_reg   <= 16'd0;
            pitch_state_reg <= '0;
            roll_state_reg  <= '0;
            roll_sel_reg    <= 1'b0;
            clip_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                step_time_reg <= cfg_wr_data;
            if (accept)
            begin
                chan_reg     <= CH_AX;
                roll_sel_reg <= 1'b0;
                clip_reg     <= 1'b0;
            end
            if (state_reg == S_DWAIT && div_done && chan_reg != CH_GY)
                chan_reg <= chan_t'(chan_reg + 3'd1);
            if (state_reg == S_BADD)
            begin
                if (roll_sel_reg)
                    roll_state_reg <= n_clamped;
                else
                    pitch_state_reg <= n_clamped;
                roll_sel_reg <= 1'b1;
                if (n_clip)
                    clip_reg <= 1'b1;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_axis_tready))
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= s_axis_tdata[15:0];
            ay_reg <= s_axis_tdata[31:16];
            az_reg <= s_axis_tdata[47:32];
            gx_reg <= s_axis_tdata[63:48];
            gy_reg <= s_axis_tdata[79:64];
        end
        // sign of the current channel
        if (state_reg == S_MUL)
            neg_reg <= neg_sel;
        if (state_reg == S_DWAIT && div_done)
        begin
            case (chan_reg)
                CH_AX:   axq_reg <= quo_s[ACC_W-1:0];
                CH_AY:   ayq_reg <= quo_s[ACC_W-1:0];
                CH_AZ:   azq_reg <= quo_s[ACC_W-1:0];
                CH_GX:   rate_roll_reg <= quo_s;
                default: rate_pitch_reg <= quo_s;
            endcase
        end
        if (state_reg == S_SQY || state_reg == S_SQZ)
            sq_reg <= sq_full[40:0];
        if (state_reg == S_SQZ)
            y2_reg <= sq_reg[40:32];
        if (state_reg == S_CWAITP && cor_done)
            acc_pitch_reg <= -cor_angle;
        if (state_reg == S_CWAITR && cor_done)
            acc_roll_reg <= cor_angle;
        if (state_reg == S_DIFF)
            diff_reg <= DIFF_W'(rate_cur) + DIFF_W'(acc_cur) - DIFF_W'(s_cur);
        if (state_reg == S_BMUL)
            bprod_reg <= diff_reg * $signed({1'b0, step_time_reg});
        if (state_reg == S_DONE && (!m_valid_reg || m_axis_tready))
            m_data_reg <= {7'd0, clip_reg, to_out(roll_state_reg), to_out(pitch_state_reg)};
    end

    // arithmetic units; the divider and the CORDIC unit are shared between passes
    ctf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (mag),
        .acc_sel  (is_acc),
        .done     (div_done),
        .quotient (quo)
    );

    ctf_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    ctf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .done  (cor_done),
        .angle (cor_angle)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks
    `CTF_ASSERT_IMPL(a_div_done_wait, div_done, state_reg == S_DWAIT, "divider done outside wait")
    `CTF_ASSERT_IMPL(a_cor_done_wait, cor_done, (state_reg == S_CWAITP) || (state_reg == S_CWAITR), "cordic done outside wait")
    `CTF_ASSERT_NEXT(a_accept_start, accept, (state_reg == S_MUL) && (chan_reg == CH_AX), "accepted word did not start scaling")
    `CTF_ASSERT_IMPL(a_angle_bound, 1'b1, (pitch_state_reg <= ANGLE_LIMIT) && (pitch_state_reg >= -ANGLE_LIMIT) && (roll_state_reg <= ANGLE_LIMIT) && (roll_state_reg >= -ANGLE_LIMIT), "angle state out of range")

endmodule
`default_nettype wire

@@ bench/imu_complementary_tilt_filter_tb.sv @@
`default_nettype none
module imu_complementary_tilt_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 20000;
    localparam longint PI_Q_REF = 52707179;
    localparam longint ANGLE_MAX = 67108864;
    localparam int N_ITER = 16;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic               clip;
    } tilt_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    // predictor state
    longint      pitch_q;
    longint      roll_q;
    longint      dt_q;
    tilt_word_t  tilt_queue[$];
    int          n_err;
    int          n_sent;
    int          n_seen;
    int          idle_cnt;
    bit          calm;

    longint atan_lut_q[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2};

    imu_complementary_tilt_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // floor shift (>>> on longint is arithmetic)
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
        longint z;
        longint off;
        longint xs;
        longint ys;
        begin
            z = 0;
            off = 0;
            if (y == 0)
                return (x < 0) ? PI_Q_REF : 0;
            if (x < 0)
            begin
                off = (y >= 0) ? PI_Q_REF : -PI_Q_REF;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < N_ITER && i < 24; i++)
            begin
                xs = fshr(x, i);
                ys = fshr(y, i);
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; z += atan_lut_q[i];
                end
                else
                begin
                    x = x - ys; y = y + xs; z -= atan_lut_q[i];
                end
            end
            return off + z;
        end
    endfunction

    function automatic longint int_root(longint v);
        longint root;
        longint b;
        begin
            root = 0;
            b = longint'(1) << 42;
            for (int k = 0; k < 22; k++)
            begin
                if (v >= root + b)
                begin
                    v -= root + b;
                    root = (root >> 1) + b;
                end
                else
                    root = root >> 1;
                b = b >> 2;
            end
            return root;
        end
    endfunction

    function automatic longint accel_q(logic signed [15:0] raw);
        longint a;
        begin
            a = -longint'(raw);
            if (a > 32767) a = 32767;
            return (a * 98 * 65536) / 163275;
        end
    endfunction

    function automatic longint blend_angle(longint s, longint rate, longint acc, ref bit clip);
        longint n;
        begin
            n = s + fshr((rate + acc - s) * dt_q + 32768, 16);
            if (n > ANGLE_MAX)
            begin
                n = ANGLE_MAX; clip = 1;
            end
            else if (n < -ANGLE_MAX)
            begin
                n = -ANGLE_MAX; clip = 1;
            end
            return n;
        end
    endfunction

    function automatic logic [15:0] angle_word(longint s);
        longint v;
        begin
            v = fshr(s, 11);
            if (v > 32767) v = 32767;
            return v[15:0];
        end
    endfunction

    // work out the expected word for one sample set
    task automatic predict_tilt(logic [95:0] d);
        longint ax, ay, az, rr, pr, y2, z2, r, ap, ar;
        bit clip;
        tilt_word_t w;
        begin
            ax = accel_q(d[15:0]);
            ay = accel_q(d[31:16]);
            az = accel_q(d[47:32]);
            rr = (longint'($signed(d[63:48])) * PI_Q_REF * 5) / 58779;
            pr = (longint'($signed(d[79:64])) * PI_Q_REF * 5) / 58779;
            y2 = (ay * ay) >> 32;
            z2 = (az * az) >> 32;
            r = int_root((y2 + z2) << 32);
            ap = -cordic_angle(ax * 256, r * 256);
            ar = cordic_angle(ay * 256, az * 256);
            clip = 0;
            pitch_q = blend_angle(pitch_q, pr, ap, clip);
            roll_q = blend_angle(roll_q, rr, ar, clip);
            w.pitch = angle_word(pitch_q);
            w.roll = angle_word(roll_q);
            w.clip = clip;
            tilt_queue.push_back(w);
        end
    endtask

    // send one sample set, with an optional gap first
    task automatic send_set(logic [95:0] d);
        begin
            if (!calm && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) @(negedge clk);
            s_axis_tdata <= d;
            s_axis_tvalid <= 1'b1;
            do @(posedge clk); while (!s_axis_tready);
            predict_tilt(d);
            n_sent++;
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            // the block is busy after each accepted set, so the next word need not follow at once
            @(negedge clk);
        end
    endtask

    task automatic send_axes(int ax, int ay, int az, int gx, int gy, int gz);
        send_set({16'(gz), 16'(gy), 16'(gx), 16'(az), 16'(ay), 16'(ax)});
    endtask

    // wait for all words, let the block settle, then write step_time
    task automatic set_step_time(logic [15:0] v);
        begin
            while (tilt_queue.size() != 0) @(negedge clk);
            repeat (300) @(negedge clk);
            cfg_wr_data <= v;
            cfg_wr_en <= 1'b1;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            dt_q = v;
        end
    endtask

    function automatic logic [95:0] rand_set();
        logic [95:0] d;
        begin
            for (int i = 0; i < 3; i++) d[i*32 +: 32] = $urandom;
            return d;
        end
    endfunction

    function automatic logic [15:0] rand_small(int lim);
        return 16'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    // tests
    task automatic test_zero_step();
        begin
            send_axes(0, 0, 0, 0, 0, 0);
            send_axes(-32768, -32768, -32768, 32767, -32768, 0);
            send_axes(32767, 32767, 32767, -32768, 32767, 32767);
        end
    endtask

    task automatic test_corner_vectors();
        begin
            set_step_time(16'd65535);
            send_axes(0, 0, 0, 0, 0, 0);
            send_axes(0, 0, 5000, 0, 0, 0);
            send_axes(0, 0, -5000, 0, 0, 0);
            send_axes(100, 4000, -3000, 0, 0, 0);
            send_axes(-100, -4000, -3000, 0, 0, 0);
            send_axes(-32768, -32768, -32768, 0, 0, 0);
            send_axes(32767, 0, 16000, 0, 0, 0);
            send_axes(-32768, 0, 0, 0, 0, 0);
            send_axes(0, 0, 0, 32767, 32767, 0);
            send_axes(0, 0, 0, 32767, 32767, 0);
            send_axes(0, 0, 0, -32768, -32768, -32768);
            send_axes(0, 0, 0, -32768, -32768, -32768);
            set_step_time(16'd1);
            send_axes(1000, 2000, 3000, 100, -100, 7);
            set_step_time(16'd32768);
            send_axes(-1000, 2000, -3000, -100, 100, 7);
        end
    endtask

    task automatic test_random_sets(int n);
        logic [95:0] d;
        begin
            for (int i = 0; i < n; i++)
            begin
                if (i % 100 == 0)
                    set_step_time(16'($urandom));
                if ($urandom_range(0, 1))
                    d = rand_set();
                else
                    d = {rand_small(32768), rand_small(2000), rand_small(2000),
                         rand_small(20000), rand_small(20000), rand_small(20000)};
                if (i > n - 100)
                    calm = 1;
                send_set(d);
            end
        end
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (calm || $urandom_range(0, 3) != 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= 1'b0;
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        tilt_word_t got;
        tilt_word_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= TIMEOUT_CYCLES)
            begin
                $display("watchdog: no traffic for %0d cycles", TIMEOUT_CYCLES);
                $display("Verification failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pitch = m_axis_tdata[15:0];
                got.roll = m_axis_tdata[31:16];
                got.clip = m_axis_tdata[32];
                n_seen++;
                if (tilt_queue.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $realtime, m_axis_tdata);
                    n_err++;
                end
                else
                begin
                    want = tilt_queue.pop_front();
                    if (got.pitch !== want.pitch)
                    begin
                        $display("%0t: pitch expected %0d actual %0d", $realtime,
                                 want.pitch, got.pitch);
                        n_err++;
                    end
                    if (got.roll !== want.roll)
                    begin
                        $display("%0t: roll expected %0d actual %0d", $realtime,
                                 want.roll, got.roll);
                        n_err++;
                    end
                    if (got.clip !== want.clip)
                    begin
                        $display("%0t: clipped expected %0b actual %0b", $realtime,
                                 want.clip, got.clip);
                        n_err++;
                    end
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        pitch_q = 0;
        roll_q = 0;
        dt_q = 0;
        n_err = 0;
        n_sent = 0;
        n_seen = 0;
        idle_cnt = 0;
        calm = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_step();
        test_corner_vectors();
        test_random_sets(800);

        while (tilt_queue.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        $display("sent %0d sample sets, checked %0d words over several step times",
                 n_sent, n_seen);
        if (n_err == 0 && tilt_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
